// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

// ===== rtl/scss_pkg.sv =====
`default_nettype none

package scss_pkg;

  // Line buffer length; only the first LINE_MAX-1 characters of a line count.
  localparam int LINE_MAX   = 20;
  localparam int LINE_CNT_W = $clog2(LINE_MAX);

  localparam int POS_W   = 15;
  localparam int POS_MAX = 32767;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_THRESHOLD = 2'd1;

  localparam logic [CFG_DATA_W-1:0] STEP_SIZE_RESET      = 8'd8;
  localparam logic [CFG_DATA_W-1:0] SNAP_THRESHOLD_RESET = 8'd16;

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Characters of interest.
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_Y   = 8'h79;
  localparam logic [7:0] CHAR_P   = 8'h70;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_AXIS1 = 2'd1,
    CMD_AXIS2 = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] goal_first;
    logic [POS_W-1:0] goal_second;
  } out_item_t;

  // Both axis targets as held by the parser.
  typedef struct packed {
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] second;
  } targets_t;

endpackage

`default_nettype wire

// ===== rtl/scss_parser.sv =====
`default_nettype none

`include "assert_macros.svh"

module scss_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_en,
  input  wire logic [7:0]        rx_byte,
  output scss_pkg::targets_t     targets
);
  import scss_pkg::*;

  localparam logic [LINE_CNT_W-1:0] LINE_LAST = LINE_CNT_W'(LINE_MAX - 1);

  logic [LINE_CNT_W-1:0] line_count, line_count_next;
  cmd_kind_t             command_kind, command_kind_next;
  logic [POS_W-1:0]      digit_value, digit_value_next;
  logic                  digits_open, digits_open_next;
  logic                  text_ended, text_ended_next;
  targets_t              targets_next;

  logic                  is_digit;
  logic [18:0]           digit_acc;
  logic                  text_end_now;

  assign is_digit = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);

  // Value times ten plus the new digit, built from two shifts.
  assign digit_acc = {1'b0, digit_value, 3'b000} + {3'b000, digit_value, 1'b0}
                   + {15'd0, rx_byte[3:0]};

  assign text_end_now = text_ended || (rx_byte == CHAR_NUL);

  // Next line state for one received byte.
  always_comb begin
    line_count_next   = line_count;
    command_kind_next = command_kind;
    digit_value_next  = digit_value;
    digits_open_next  = digits_open;
    text_ended_next   = text_ended;
    targets_next      = targets;
    if (byte_en) begin
      if (rx_byte == CHAR_LF) begin
        // End of line: commit the value to the named axis and start over.
        unique case (command_kind)
          CMD_AXIS1: targets_next.first  = digit_value;
          CMD_AXIS2: targets_next.second = digit_value;
          default: begin
          end
        endcase
        line_count_next   = '0;
        command_kind_next = CMD_NONE;
        digit_value_next  = '0;
        digits_open_next  = 1'b1;
        text_ended_next   = 1'b0;
      end else if ((rx_byte != CHAR_CR) && (line_count < LINE_LAST)) begin
        text_ended_next = text_end_now;
        if (line_count == '0) begin
          if (rx_byte == CHAR_Y) begin
            command_kind_next = CMD_AXIS1;
          end else if (rx_byte == CHAR_P) begin
            command_kind_next = CMD_AXIS2;
          end else begin
            command_kind_next = CMD_NONE;
          end
        end else if (digits_open && !text_end_now && is_digit) begin
          if (digit_acc > 19'(POS_MAX)) begin
            digit_value_next = POS_W'(POS_MAX);
          end else begin
            digit_value_next = digit_acc[POS_W-1:0];
          end
        end else begin
          digits_open_next = 1'b0;
        end
        line_count_next = line_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      command_kind <= CMD_NONE;
      digit_value  <= '0;
      digits_open  <= 1'b1;
      text_ended   <= 1'b0;
      targets      <= '0;
    end else begin
      line_count   <= line_count_next;
      command_kind <= command_kind_next;
      digit_value  <= digit_value_next;
      digits_open  <= digits_open_next;
      text_ended   <= text_ended_next;
      targets      <= targets_next;
    end
  end

  `ASSERT_IMPL(a_line_bound, clk, rst, 1'b1, line_count <= LINE_LAST)
  `ASSERT_NEXT(a_newline_clears, clk, rst, byte_en && (rx_byte == CHAR_LF),
               (line_count == '0) && digits_open && (digit_value == '0))

endmodule

`default_nettype wire

// ===== rtl/serial_command_servo_slew.sv =====
`default_nettype none

`include "assert_macros.svh"

// Two-axis slew controller driven by a text command stream. Byte items build
// a line: "y<digits>" sets the target of axis one and "p<digits>" the target
// of axis two, committed when the newline arrives. Each tick item moves both
// axes toward their targets by step_size (snapping when closer than
// snap_threshold) and produces one result with both goal positions. An item
// is accepted every cycle unless a tick waits in the input register; each
// item sits in the input register while the parser or slew logic computes
// the value that is loaded into the result register. A stalled result holds
// the result register, and the input register then holds the next tick;
// byte items keep flowing while a result waits. Registers are written
// through the configuration port, which is always ready.
module serial_command_servo_slew (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire scss_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output scss_pkg::out_item_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [scss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scss_pkg::*;

  logic [CFG_DATA_W-1:0] step_size;
  logic [CFG_DATA_W-1:0] snap_threshold;

  in_item_t         stage;
  logic             stage_valid;
  logic             out_free;
  logic             advance;
  logic             take_tick;
  logic             take_byte;
  targets_t         targets;
  logic [POS_W-1:0] cur_first, cur_second;
  logic [POS_W-1:0] cur_first_next, cur_second_next;

  // One axis step: snap when close, otherwise move by the step and clamp.
  function automatic logic [POS_W-1:0] slew(input logic [POS_W-1:0] cur,
                                            input logic [POS_W-1:0] tgt,
                                            input logic [CFG_DATA_W-1:0] step,
                                            input logic [CFG_DATA_W-1:0] snap);
    logic signed [POS_W+1:0] delta;
    logic        [POS_W:0]   mag;
    logic        [POS_W+1:0] sum;
    logic signed [POS_W+1:0] diff;
    logic        [POS_W-1:0] res;
    delta = $signed({2'b00, tgt}) - $signed({2'b00, cur});
    mag   = delta[POS_W+1] ? (POS_W+1)'(-delta) : delta[POS_W:0];
    sum   = {2'b00, cur} + {{(POS_W+2-CFG_DATA_W){1'b0}}, step};
    diff  = $signed({2'b00, cur}) - $signed({{(POS_W+2-CFG_DATA_W){1'b0}}, step});
    if (mag < {{(POS_W+1-CFG_DATA_W){1'b0}}, snap}) begin
      res = tgt;
    end else if (!delta[POS_W+1] && (delta != '0)) begin
      res = (sum > (POS_W+2)'(POS_MAX)) ? POS_W'(POS_MAX) : sum[POS_W-1:0];
    end else if (delta[POS_W+1]) begin
      res = diff[POS_W+1] ? '0 : diff[POS_W-1:0];
    end else begin
      res = cur;
    end
    return res;
  endfunction

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= STEP_SIZE_RESET;
      snap_threshold <= SNAP_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:      step_size      <= cfg_data;
        CFG_SNAP_THRESHOLD: snap_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Flow control: a byte always drains, a tick needs room in the result register.
  assign out_free  = !out_valid || !out_stall;
  assign advance   = stage_valid && ((stage.kind == KIND_BYTE) || out_free);
  assign take_tick = advance && (stage.kind == KIND_TICK);
  assign take_byte = advance && (stage.kind == KIND_BYTE);
  assign in_stall  = stage_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage <= in_data;
    end
  end

  scss_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .byte_en (take_byte),
    .rx_byte (stage.rx_byte),
    .targets (targets)
  );

  // Slew both axes on a tick.
  always_comb begin
    cur_first_next  = slew(cur_first, targets.first, step_size, snap_threshold);
    cur_second_next = slew(cur_second, targets.second, step_size, snap_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_first  <= '0;
      cur_second <= '0;
    end else if (take_tick) begin
      cur_first  <= cur_first_next;
      cur_second <= cur_second_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_tick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      out_data.goal_first  <= cur_first_next;
      out_data.goal_second <= cur_second_next;
    end
  end

  `ASSERT_IMPL(a_stall_needs_item, clk, rst, in_stall, stage_valid && (stage.kind == KIND_TICK))
  `ASSERT_NEXT(a_result_kept, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_byte_no_result, clk, rst, take_byte && !out_valid, !out_valid)
  `ASSERT_NEXT(a_tick_result, clk, rst, take_tick,
               out_valid && (out_data.goal_first == cur_first))

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
  import scss_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  serial_command_servo_slew dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Items waiting to be sent and goal pairs waiting to come back.
  in_item_t  pending_items[$];
  out_item_t goal_queue[$];
  int        fault_count  = 0;
  logic      in_fire_seen = 1'b0;
  logic      calm         = 1'b0;

  // Predictor state: register copies, line parser and both axes.
  logic [CFG_DATA_W-1:0] model_step = STEP_SIZE_RESET;
  logic [CFG_DATA_W-1:0] model_snap = SNAP_THRESHOLD_RESET;
  logic [LINE_CNT_W-1:0] line_len    = '0;
  cmd_kind_t             line_cmd    = CMD_NONE;
  logic [POS_W-1:0]      line_value  = '0;
  logic                  digits_live = 1'b1;
  logic                  text_over   = 1'b0;
  logic [POS_W-1:0]      goal_target[2] = '{'0, '0};
  logic [POS_W-1:0]      goal_pos[2]    = '{'0, '0};

  // One character of a line; anything past the line limit is dropped.
  function automatic void parse_char(input logic [7:0] c);
    int nv;
    if (int'(line_len) < LINE_MAX - 1) begin
      if (c == CHAR_NUL) text_over = 1'b1;
      if (line_len == '0) begin
        if (c == CHAR_Y) line_cmd = CMD_AXIS1;
        else if (c == CHAR_P) line_cmd = CMD_AXIS2;
        else line_cmd = CMD_NONE;
      end else if (digits_live && !text_over) begin
        if (c >= CHAR_0 && c <= CHAR_9) begin
          nv = int'(line_value) * 10 + int'(c - CHAR_0);
          line_value = (nv > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(nv);
        end else begin
          digits_live = 1'b0;
        end
      end else begin
        digits_live = 1'b0;
      end
      line_len = line_len + 1'b1;
    end
  endfunction

  // The newline commits the parsed target and starts a fresh line.
  function automatic void close_line();
    if (line_cmd == CMD_AXIS1) goal_target[0] = line_value;
    else if (line_cmd == CMD_AXIS2) goal_target[1] = line_value;
    line_len    = '0;
    line_cmd    = CMD_NONE;
    line_value  = '0;
    digits_live = 1'b1;
    text_over   = 1'b0;
  endfunction

  // Move one axis toward its target, snapping when close, clamped to range.
  function automatic logic [POS_W-1:0] slew_step(input logic [POS_W-1:0] pos,
                                                 input logic [POS_W-1:0] tgt);
    int diff, gap, nxt;
    diff = int'(tgt) - int'(pos);
    gap  = (diff < 0) ? -diff : diff;
    if (gap < int'(model_snap)) nxt = int'(tgt);
    else if (diff > 0) nxt = int'(pos) + int'(model_step);
    else if (diff < 0) nxt = int'(pos) - int'(model_step);
    else nxt = int'(pos);
    if (nxt < 0) nxt = 0;
    if (nxt > POS_MAX) nxt = POS_MAX;
    return POS_W'(nxt);
  endfunction

  // Input driver: hold a stalled transfer, otherwise offer the next item.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_seen) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
        in_valid <= 1'b1;
        in_data  <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 15);
  end

  // Monitor: track register writes, predict on input transfers, check results.
  always @(posedge clk) begin
    in_item_t  item;
    out_item_t want;
    if (rst) begin
      in_fire_seen = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STEP_SIZE) model_step = cfg_data;
        else if (cfg_index == CFG_SNAP_THRESHOLD) model_snap = cfg_data;
      end

      in_fire_seen = in_valid && !in_stall;
      if (in_fire_seen) begin
        item = in_data;
        void'(pending_items.pop_front());
        if (item.kind == KIND_TICK) begin
          goal_pos[0] = slew_step(goal_pos[0], goal_target[0]);
          goal_pos[1] = slew_step(goal_pos[1], goal_target[1]);
          want.goal_first  = goal_pos[0];
          want.goal_second = goal_pos[1];
          goal_queue.push_back(want);
        end else if (item.rx_byte == CHAR_LF) begin
          close_line();
        end else if (item.rx_byte != CHAR_CR) begin
          parse_char(item.rx_byte);
        end
      end

      if (out_valid && !out_stall) begin
        if (goal_queue.size() == 0) begin
          if (fault_count < 10)
            $display("unexpected result: goal_first=%0d goal_second=%0d",
                     out_data.goal_first, out_data.goal_second);
          fault_count++;
        end else begin
          want = goal_queue.pop_front();
          if (out_data.goal_first !== want.goal_first ||
              out_data.goal_second !== want.goal_second) begin
            if (fault_count < 10)
              $display("goal mismatch: expected %0d/%0d, got %0d/%0d",
                       want.goal_first, want.goal_second,
                       out_data.goal_first, out_data.goal_second);
            fault_count++;
          end
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    in_item_t item;
    item.kind    = KIND_BYTE;
    item.rx_byte = b;
    pending_items.push_back(item);
  endtask

  // A tick carries a meaningless byte, which is varied too.
  task automatic push_tick(input logic [7:0] junk);
    in_item_t item;
    item.kind    = KIND_TICK;
    item.rx_byte = junk;
    pending_items.push_back(item);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_prefix();
    return $urandom_range(1) ? CHAR_Y : CHAR_P;
  endfunction

  // Mostly well-formed commands with random values, plus noise, overlong
  // lines and lines cut by a NUL, each followed by up to three ticks or, now and then, by 10 to 30.
  task automatic add_random_items(input int target);
    int    roll;
    int    v;
    string digits;
    while (pending_items.size() < target) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        push_byte(pick_prefix());
        case ($urandom_range(4))
          0: v = 0;
          1: v = POS_MAX;
          2: v = $urandom_range(99999, 32768);
          3: v = $urandom_range(400);
          default: v = $urandom_range(POS_MAX);
        endcase
        digits = $sformatf("%0d", v);
        if ($urandom_range(9) == 0) digits = {"00", digits};
        push_text(digits);
        if ($urandom_range(4) == 0) begin
          push_byte(8'($urandom_range(255)));
          push_text("42");
        end
        if ($urandom_range(9) == 0) push_byte(CHAR_CR);
      end else if (roll < 77) begin
        repeat ($urandom_range(25)) push_byte(8'($urandom_range(255)));
      end else if (roll < 87) begin
        push_byte(pick_prefix());
        repeat ($urandom_range(24, 17)) push_byte(CHAR_0 + 8'($urandom_range(9)));
      end else begin
        if ($urandom_range(1) == 0) push_byte(CHAR_NUL);
        push_byte(pick_prefix());
        push_byte(CHAR_0 + 8'($urandom_range(9)));
        push_byte(CHAR_NUL);
        push_text("77");
      end
      push_byte(CHAR_LF);
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(30, 10)) push_tick(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(3)) push_tick(8'($urandom_range(255)));
      end
    end
  endtask

  // Wait until every item is sent and every result is back, then let the
  // pipeline drain, since byte items leave nothing to wait for.
  task automatic wait_quiet();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || goal_queue.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reconfigure while idle, then queue a batch of random traffic.
  task automatic run_phase(input logic [7:0] step, input logic [7:0] snap,
                           input logic no_idle, input int items);
    wait_quiet();
    calm = no_idle;
    write_reg(CFG_STEP_SIZE, step);
    write_reg(CFG_SNAP_THRESHOLD, snap);
    @(negedge clk) cfg_valid <= 1'b0;
    @(posedge clk);
    add_random_items(items);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // Directed lines at reset settings: saturating value with a carriage
    // return, prefix only, empty line, NUL inside the digits, NUL first.
    push_text("y99999");
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_tick(8'hff);
    push_text("p");
    push_byte(CHAR_LF);
    push_byte(CHAR_LF);
    push_tick(8'h00);
    push_text("y1");
    push_byte(CHAR_NUL);
    push_text("5");
    push_byte(CHAR_LF);
    push_byte(CHAR_NUL);
    push_text("y3");
    push_byte(CHAR_LF);
    push_tick(8'h5a);
    add_random_items(120);

    run_phase(8'd1,   8'd1,   1'b0, 105);
    run_phase(8'd255, 8'd255, 1'b1, 105);
    run_phase(8'd0,   8'd0,   1'b0, 105);
    run_phase(8'd255, 8'd1,   1'b0, 105);
    run_phase(8'd1,   8'd255, 1'b0, 105);
    run_phase(8'd0,   8'd255, 1'b0, 105);
    run_phase(8'd37,  8'd90,  1'b0, 105);

    wait_quiet();
    if (fault_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
